@@ design/assert_macros.svh @@
// Assertion macros for the sliding RMS top-level design file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside of reset
`define SRWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding rms assertion failed");

// Check that cons holds in the cycle after ante, outside of reset
`define SRWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding rms assertion failed");

`endif

@@ design/srws_pkg.sv @@
// Shared constants and types for the sliding RMS block.
// No dependencies; srws_sqmul, srws_sqrt and the top level use it by scoped names.
package srws_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int RMS_W    = 16;
  localparam int HOP_W    = 13;
  localparam logic [HOP_W-1:0] HOP_RESET = 13'd32;

  // Default window lengths
  localparam int DEF_WINDOW      = 256;
  localparam int DEF_LONG_WINDOW = 16;

  // Serial multiplier: magnitudes of sample difference and sum
  localparam int MAG_W  = SAMPLE_W + 1;
  localparam int PROD_W = 2 * MAG_W;

  // Serial square root: mean square fits in 32 bits, root in 16
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RSH_W  = ROOT_W + 4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_SQRT,
    S_DIV2,
    S_EMIT
  } state_t;

endpackage

@@ design/srws_sqmul.sv @@
// Bit-serial multiplier that forms new^2 - old^2 as (new-old)*(new+old).
// Depends on srws_pkg for widths; one multiplier bit per cycle.
module srws_sqmul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [srws_pkg::SAMPLE_W-1:0] new_smp,
  input  logic signed [srws_pkg::SAMPLE_W-1:0] old_smp,
  output logic                              done,
  output logic                              neg,
  output logic [srws_pkg::PROD_W-1:0]       prod
);

  localparam int MW = srws_pkg::MAG_W;
  localparam int CW = $clog2(MW);

  logic [MW-1:0]                  diff, summ, diff_mag, summ_mag;
  logic [MW-1:0]                  a_r;
  logic [srws_pkg::PROD_W-1:0]    p_r;
  logic [MW:0]                    part;
  logic [CW-1:0]                  cnt_r;
  logic                           busy_r, done_r, neg_r;

  // Form difference and sum in one extra bit, then their magnitudes
  always_comb begin
    diff     = {new_smp[srws_pkg::SAMPLE_W-1], new_smp}
             - {old_smp[srws_pkg::SAMPLE_W-1], old_smp};
    summ     = {new_smp[srws_pkg::SAMPLE_W-1], new_smp}
             + {old_smp[srws_pkg::SAMPLE_W-1], old_smp};
    diff_mag = diff[MW-1] ? (~diff + 1'b1) : diff;
    summ_mag = summ[MW-1] ? (~summ + 1'b1) : summ;
  end

  // Add the multiplicand into the upper half when the low bit is set
  assign part = {1'b0, p_r[srws_pkg::PROD_W-1:MW]} + (p_r[0] ? {1'b0, a_r} : '0);

  // Control: step count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(MW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: load operands, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= diff_mag;
      p_r   <= {{MW{1'b0}}, summ_mag};
      neg_r <= diff[MW-1] ^ summ[MW-1];
    end else if (busy_r) begin
      p_r <= {part, p_r[MW-1:1]};
    end
  end

  assign done = done_r;
  assign neg  = neg_r;
  assign prod = p_r;

endmodule

@@ design/srws_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both means.
// Depends on srws_pkg only through the top level's choice of widths.
module srws_div #(
  parameter int NW = 39,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, den_r, rem_nxt;
  logic [DW:0]   r_sh, r_diff;
  logic          ge;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // Shift in the next numerator bit and trial-subtract the divisor
  always_comb begin
    r_sh    = {rem_r, q_r[NW-1]};
    r_diff  = r_sh - {1'b0, den_r};
    ge      = (r_sh >= {1'b0, den_r});
    rem_nxt = ge ? r_diff[DW-1:0] : r_sh[DW-1:0];
  end

  // Control: step count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: numerator shifts out the top as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ design/srws_sqrt.sv @@
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on srws_pkg for radicand and root widths.
module srws_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srws_pkg::RAD_W-1:0]    rad,
  output logic                          done,
  output logic [srws_pkg::ROOT_W-1:0]   root
);

  localparam int RW = srws_pkg::ROOT_W;
  localparam int CW = $clog2(RW);

  logic [srws_pkg::RAD_W-1:0] rad_r;
  logic [srws_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [RW-1:0]              root_r;
  logic [srws_pkg::RSH_W-1:0] rem_sh, trial, r_diff;
  logic                       ge;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;

  // Bring down two bits and try root*4+1
  always_comb begin
    rem_sh  = {rem_r, rad_r[srws_pkg::RAD_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    r_diff  = rem_sh - trial;
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? r_diff[srws_pkg::REM_W-1:0] : rem_sh[srws_pkg::REM_W-1:0];
  end

  // Control: step count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(RW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: radicand shifts left two bits, root gains one bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[srws_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ design/sliding_rms_with_smoothing.sv @@
// Sliding-window RMS of signed samples, smoothed by a moving average.
// Uses: in_valid/in_stall carry one signed sample per request; out_valid/
// out_stall carry one result (short_rms, avg_rms) every hop_size
// samples (hop_size of 0 acts as 1). cfg_we/cfg_wdata write hop_size;
// the user must write it only while the block is idle (not enforced).
// Flow: a sample holds in_stall high, and no new sample is taken, while
// the 17-step serial multiplier forms new^2 - old^2. A sample that closes
// a hop then passes through the shared bit-serial divider (mean square;
// SQW = 39 with a 256-sample window), the 16-step serial square root and
// the divider again (smoothing mean); in_stall stays high until its
// result is loaded into the output register.
// Output: results sit in an output register; the block keeps taking
// samples while one waits, and holds a new result back only while the
// previous one has not yet been taken.
// Reset: synchronous, active low. Both rings read as zero until written,
// tracked by a wrap flag and a fill count, so no clearing pass is needed.
// hop_size resets to 32.
// Depends on srws_pkg, srws_sqmul, srws_div, srws_sqrt, assert_macros.svh.
`include "assert_macros.svh"

module sliding_rms_with_smoothing #(
  parameter int WINDOW      = srws_pkg::DEF_WINDOW,
  parameter int LONG_WINDOW = srws_pkg::DEF_LONG_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [srws_pkg::HOP_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [srws_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [srws_pkg::RMS_W-1:0]           out_short_rms,
  output logic [srws_pkg::RMS_W-1:0]           out_avg_rms
);

  localparam int SPW     = $clog2(WINDOW);
  localparam int SQW_MIN = 31 + SPW;
  localparam int SQW     = (SQW_MIN > srws_pkg::PROD_W + 1) ? SQW_MIN
                                                            : srws_pkg::PROD_W + 1;
  localparam int RPW     = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
  localparam int FW      = $clog2(LONG_WINDOW + 1);
  localparam int RSW     = srws_pkg::RMS_W + $clog2(LONG_WINDOW);
  localparam int DWA     = $clog2(WINDOW + 1);
  localparam int DW      = (DWA > FW) ? DWA : FW;
  localparam int SW      = srws_pkg::SAMPLE_W;
  localparam int MW      = srws_pkg::RMS_W;
  localparam int HW      = srws_pkg::HOP_W;

  srws_pkg::state_t state_r, state_nxt;

  // Storage
  logic [SW-1:0]  sample_mem [WINDOW];
  logic [MW-1:0]  rms_mem [LONG_WINDOW];
  logic [SW-1:0]  samp_rdata_r;
  logic [MW-1:0]  rms_rdata_r;
  logic [SPW-1:0] sample_pos_r;
  logic           sample_full_r;
  logic [SQW-1:0] sq_sum_r, sq_sum_nxt;
  logic [HW-1:0]  hop_size_r, hop_count_r;
  logic [HW:0]    hop_next;
  logic           hop_hit;
  logic [RPW-1:0] rms_pos_r;
  logic [FW-1:0]  rms_fill_r, rms_fill_nxt;
  logic           rms_full;
  logic [RSW-1:0] rms_sum_r, rms_sum_nxt;
  logic [MW-1:0]  rms_old, short_rms_r;
  logic           out_valid_r;
  logic [MW-1:0]  out_short_r, out_smooth_r;

  // Unit handshakes
  logic                            in_take, out_free, out_load;
  logic                            mul_start, mul_done, mul_neg;
  logic [srws_pkg::PROD_W-1:0]     mul_prod;
  logic signed [SW-1:0]            old_smp;
  logic                            div_start, div_done;
  logic [SQW-1:0]                  div_num, div_quo;
  logic [DW-1:0]                   div_den;
  logic                            sqrt_start, sqrt_done;
  logic [srws_pkg::ROOT_W-1:0]     sqrt_root;

  // Serial units
  srws_sqmul u_sqmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .new_smp (in_sample),
    .old_smp (old_smp),
    .done    (mul_done),
    .neg     (mul_neg),
    .prod    (mul_prod)
  );

  srws_div #(
    .NW (SQW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  srws_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (div_quo[srws_pkg::RAD_W-1:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Request handshake and output register availability
  assign in_stall = (state_r != srws_pkg::S_IDLE);
  assign in_take  = in_valid && (state_r == srws_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Oldest sample reads as zero until the ring has wrapped once
  assign old_smp = sample_full_r ? samp_rdata_r : '0;

  // Running sums and counters
  always_comb begin
    sq_sum_nxt   = mul_neg ? (sq_sum_r - SQW'(mul_prod)) : (sq_sum_r + SQW'(mul_prod));
    hop_next     = {1'b0, hop_count_r} + 1'b1;
    hop_hit      = (hop_next >= {1'b0, hop_size_r});
    rms_full     = (rms_fill_r == FW'(LONG_WINDOW));
    rms_old      = rms_full ? rms_rdata_r : '0;
    rms_sum_nxt  = rms_sum_r - RSW'(rms_old) + RSW'(sqrt_root);
    rms_fill_nxt = rms_full ? rms_fill_r : (rms_fill_r + 1'b1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srws_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and unit starts
  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    div_num    = SQW'(rms_sum_nxt);
    div_den    = DW'(rms_fill_nxt);
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      srws_pkg::S_IDLE: begin
        if (in_valid) begin
          mul_start = 1'b1;
          state_nxt = srws_pkg::S_MUL;
        end
      end
      srws_pkg::S_MUL: begin
        if (mul_done) begin
          if (hop_hit) begin
            div_start = 1'b1;
            div_num   = sq_sum_nxt;
            div_den   = DW'(WINDOW);
            state_nxt = srws_pkg::S_DIV1;
          end else begin
            state_nxt = srws_pkg::S_IDLE;
          end
        end
      end
      srws_pkg::S_DIV1: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_nxt  = srws_pkg::S_SQRT;
        end
      end
      srws_pkg::S_SQRT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          state_nxt = srws_pkg::S_DIV2;
        end
      end
      srws_pkg::S_DIV2: begin
        if (div_done) begin
          state_nxt = srws_pkg::S_EMIT;
        end
      end
      srws_pkg::S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = srws_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srws_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_size_r <= srws_pkg::HOP_RESET;
    end else if (cfg_we) begin
      hop_size_r <= cfg_wdata;
    end
  end

  // Sample ring: write on request, read the next slot every cycle
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_mem[sample_pos_r] <= in_sample;
    end
    samp_rdata_r <= sample_mem[sample_pos_r];
  end

  // RMS ring: write when a root completes, read the next slot every cycle
  always_ff @(posedge clk) begin
    if (state_r == srws_pkg::S_SQRT && sqrt_done) begin
      rms_mem[rms_pos_r] <= sqrt_root;
    end
    rms_rdata_r <= rms_mem[rms_pos_r];
  end

  // Advance sample position, square sum and hop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_pos_r  <= '0;
      sample_full_r <= 1'b0;
      sq_sum_r      <= '0;
      hop_count_r   <= '0;
    end else begin
      if (in_take) begin
        if (sample_pos_r == SPW'(WINDOW - 1)) begin
          sample_pos_r  <= '0;
          sample_full_r <= 1'b1;
        end else begin
          sample_pos_r <= sample_pos_r + 1'b1;
        end
      end
      if (state_r == srws_pkg::S_MUL && mul_done) begin
        sq_sum_r    <= sq_sum_nxt;
        hop_count_r <= hop_hit ? '0 : hop_next[HW-1:0];
      end
    end
  end

  // Advance RMS position, fill count and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_pos_r  <= '0;
      rms_fill_r <= '0;
      rms_sum_r  <= '0;
    end else if (state_r == srws_pkg::S_SQRT && sqrt_done) begin
      rms_pos_r  <= (rms_pos_r == RPW'(LONG_WINDOW - 1)) ? '0 : (rms_pos_r + 1'b1);
      rms_fill_r <= rms_fill_nxt;
      rms_sum_r  <= rms_sum_nxt;
    end
  end

  // Hold the short RMS while the smoothing divide runs
  always_ff @(posedge clk) begin
    if (state_r == srws_pkg::S_SQRT && sqrt_done) begin
      short_rms_r <= sqrt_root;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_short_r  <= short_rms_r;
      out_smooth_r <= div_quo[MW-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_short_rms = out_short_r;
  assign out_avg_rms   = out_smooth_r;

  // Assertions
  `SRWS_ASSERT_NOW(a_out_from_emit, $rose(out_valid_r), $past(state_r == srws_pkg::S_EMIT))
  `SRWS_ASSERT_NOW(a_mul_done_state, mul_done, state_r == srws_pkg::S_MUL)
  `SRWS_ASSERT_NOW(a_div_done_state, div_done, state_r == srws_pkg::S_DIV1 || state_r == srws_pkg::S_DIV2)
  `SRWS_ASSERT_NOW(a_sqrt_done_state, sqrt_done, state_r == srws_pkg::S_SQRT)
  `SRWS_ASSERT_NOW(a_fill_bound, 1'b1, rms_fill_r <= FW'(LONG_WINDOW))
  `SRWS_ASSERT_NEXT(a_smooth_den, state_r == srws_pkg::S_SQRT && sqrt_done, rms_fill_r != '0)

endmodule
